[design/stable_three_level_priority_queue_core_defines.svh]
// Assertion macros shared by the checker of the priority queue core.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef STABLE_THREE_LEVEL_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_THREE_LEVEL_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/spq_pkg.sv]
// Shared types, codes and sizes of the stable three-level priority queue.
// Used by every module of the block; depends on nothing.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int PAY_W    = 64;
    localparam int LEVEL_W  = 2;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((LEVEL_W + KEY_W + PAY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((KEY_W + PAY_W + LEVEL_W + COUNT_W + 7) / 8) * 8;

    localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SEARCH = 1'b1
    } state_t;

    typedef struct packed {
        logic               used;
        logic [LEVEL_W-1:0] level;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } entry_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [LEVEL_W-1:0] level;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } cell_ctrl_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

[design/stable_three_level_priority_queue_core.sv]
// Stable three-level priority queue core.
// Input channel s_axis: one operation per beat, the opcode in tuser
// (insert, remove head, lookup by key) and level, key and payload in tdata.
// Output channel m_axis: one result beat per operation, the status in tuser
// and key, payload, level and entry count in tdata.
// Entries sit in a chain of CAPACITY cells in queue order, head in cell 0.
// Insert and remove act on all cells at once in the beat's accept cycle:
// the result goes into the result register (or the skid register while the
// receiver stalls); one operation per cycle while s_axis_tready is high.
// Lookup: the cells compare in the accept cycle into a registered match
// vector and the first hit is selected in the next cycle; s_axis_tready is
// low meanwhile, so no new operation is taken until that result is formed.
// Reset empties the queue (all cell used bits cleared) and drops any result.
// A result register plus one skid register part the channels: while the
// receiver stalls one more operation is taken, then s_axis_tready drops
// until the receiver takes a beat.
module stable_three_level_priority_queue_core
    import spq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // priority_level, entry_key, entry_payload, zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic [OP_W-1:0]      s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_key, out_payload, out_level, out_count, zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]  m_axis_tuser
);

    localparam int M_PAD_W = M_TDATA_W - (KEY_W + PAY_W + LEVEL_W + COUNT_W);

    logic [LEVEL_W-1:0] in_level_raw;
    logic [LEVEL_W-1:0] in_level;
    logic [KEY_W-1:0]   in_key;
    logic [PAY_W-1:0]   in_payload;
    logic               accept;

    state_t             state_reg;
    state_t             state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    cell_ctrl_t          ctrl;
    entry_t              cell_entry [CAPACITY];
    logic [CAPACITY-1:0] stay_vec;
    logic [CAPACITY-1:0] match_vec;
    logic                capture;
    logic                found;
    entry_t              found_entry;

    result_t res;
    logic    res_push;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    take;

    assign in_level_raw = s_axis_tdata[LEVEL_W-1:0];
    assign in_key       = s_axis_tdata[LEVEL_W +: KEY_W];
    assign in_payload   = s_axis_tdata[LEVEL_W + KEY_W +: PAY_W];
    assign in_level     = (in_level_raw > LEVEL_LOW) ? LEVEL_LOW : in_level_raw;

    assign s_axis_tready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   left_stay;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_stay  = 1'b1;
            assign left_entry = '0;
        end
        else
        begin : g_body
            assign left_stay  = stay_vec[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_stay   (left_stay),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .stay        (stay_vec[i]),
            .match       (match_vec[i]),
            .entry       (cell_entry[i])
        );
    end

    spq_search u_search (
        .clk         (clk),
        .capture     (capture),
        .match       (match_vec),
        .cells       (cell_entry),
        .found       (found),
        .found_entry (found_entry)
    );

    // control and result formation
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        capture      = 1'b0;
        res_push     = 1'b0;
        ctrl.cmd     = CMD_HOLD;
        ctrl.level   = in_level;
        ctrl.key     = in_key;
        ctrl.payload = in_payload;
        res          = '0;
        res.status   = STAT_OK;
        res.count    = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        OP_INSERT:
                        begin
                            res_push = 1'b1;
                            if (count_reg == COUNT_W'(CAPACITY))
                                res.status = STAT_FULL;
                            else
                            begin
                                ctrl.cmd   = CMD_INSERT;
                                count_next = count_reg + COUNT_W'(1);
                                res.count  = count_next;
                            end
                        end
                        OP_REMOVE:
                        begin
                            res_push = 1'b1;
                            if (count_reg == '0)
                                res.status = STAT_EMPTY;
                            else
                            begin
                                ctrl.cmd    = CMD_REMOVE;
                                count_next  = count_reg - COUNT_W'(1);
                                res.count   = count_next;
                                res.key     = cell_entry[0].key;
                                res.payload = cell_entry[0].payload;
                                res.level   = cell_entry[0].level;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            capture    = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        default: res_push = 1'b1;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                res_push   = 1'b1;
                state_next = ST_IDLE;
                if (found)
                begin
                    res.key     = found_entry.key;
                    res.payload = found_entry.payload;
                    res.level   = found_entry.level;
                end
                else
                    res.status = STAT_NOTFOUND;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result register with one skid slot
    always_comb
    begin
        take            = out_valid_reg && m_axis_tready;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = res_push;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_push;
            end
        end
        else if (res_push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_reg.count, out_reg.level,
                            out_reg.payload, out_reg.key};

endmodule

[design/spq_cell.sv]
// One storage cell of the queue chain: holds an entry, shifts left or right.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       left_stay,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output logic       stay,
    output logic       match,
    output entry_t     entry
);

    logic               used_reg;
    logic               used_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [PAY_W-1:0]   payload_reg;
    logic [PAY_W-1:0]   payload_next;
    entry_t             entry_next;

    assign entry = '{used: used_reg, level: level_reg, key: key_reg, payload: payload_reg};

    always_comb
    begin
        // levels ascend along the chain, so cells that stay form a prefix
        stay  = used_reg && (level_reg <= ctrl.level);
        match = used_reg && (key_reg == ctrl.key);

        entry_next = entry;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (!stay)
                begin
                    if (left_stay)
                        entry_next = '{used: 1'b1, level: ctrl.level,
                                       key: ctrl.key, payload: ctrl.payload};
                    else
                        entry_next = left_entry;
                end
            end
            CMD_REMOVE: entry_next = right_entry;
            default:    entry_next = entry;
        endcase

        used_next    = entry_next.used;
        level_next   = entry_next.level;
        key_next     = entry_next.key;
        payload_next = entry_next.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        level_reg   <= level_next;
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

endmodule

[design/spq_search.sv]
// Lookup stage: registers the per-cell match vector, then picks the first hit.
// Depends on spq_pkg.
module spq_search
    import spq_pkg::*;
(
    input  logic                clk,
    input  logic                capture,
    input  logic [CAPACITY-1:0] match,
    input  entry_t              cells [CAPACITY],
    output logic                found,
    output entry_t              found_entry
);

    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;
    logic [CAPACITY-1:0] first_hit;

    assign match_next = capture ? match : match_reg;

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    // lowest set bit is the hit nearest the head
    assign first_hit = match_reg & (~match_reg + CAPACITY'(1));
    assign found     = |match_reg;

    always_comb
    begin
        found_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hit[i])
                found_entry = found_entry | cells[i];
        end
    end

endmodule

[design/spq_checker.sv]
// Port-level checker for the priority queue core, bound to the top level.
// Depends on spq_pkg and the shared assertion macro header.
`include "stable_three_level_priority_queue_core_defines.svh"

module spq_checker
    import spq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]  m_axis_tuser
);

    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
    logic [LEVEL_W-1:0] out_level;
    logic [COUNT_W-1:0] out_count;
    logic               no_entry;

    assign out_key     = m_axis_tdata[KEY_W-1:0];
    assign out_payload = m_axis_tdata[KEY_W +: PAY_W];
    assign out_level   = m_axis_tdata[KEY_W + PAY_W +: LEVEL_W];
    assign out_count   = m_axis_tdata[KEY_W + PAY_W + LEVEL_W +: COUNT_W];
    assign no_entry    = (out_key == '0) && (out_payload == '0) && (out_level == '0);

    `SPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result beat changed while stalled")
    `SPQ_ASSERT_NOW(a_count_bound, m_axis_tvalid, out_count <= COUNT_W'(CAPACITY),
        "entry count above capacity")
    `SPQ_ASSERT_NOW(a_full_count, m_axis_tvalid && (m_axis_tuser == STAT_FULL),
        (out_count == COUNT_W'(CAPACITY)) && no_entry,
        "full status with queue not full")
    `SPQ_ASSERT_NOW(a_empty_count, m_axis_tvalid && (m_axis_tuser == STAT_EMPTY),
        (out_count == '0) && no_entry,
        "empty status with entries held")
    `SPQ_ASSERT_NOW(a_miss_clear, m_axis_tvalid && (m_axis_tuser == STAT_NOTFOUND),
        no_entry, "lookup miss carries entry data")

endmodule

bind stable_three_level_priority_queue_core spq_checker u_spq_checker (.*);

[sim/stable_three_level_priority_queue_core_tb.sv]
// Testbench of the stable three-level priority queue core: directed and random operations
// are checked beat by beat against a predictor of the cell chain kept here.
// Depends on spq_pkg and stable_three_level_priority_queue_core.
module stable_three_level_priority_queue_core_tb;
    import spq_pkg::*;

    localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MID   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_OVER  = 2'd3;
    localparam int                 ITEMS_PER_PHASE = 420;
    localparam int                 CYCLE_LIMIT     = 200000;
    localparam int                 FIELDS_W    = KEY_W + PAY_W + LEVEL_W + COUNT_W;
    localparam logic [KEY_W-1:0]   KEY_ONES    = {KEY_W{1'b1}};

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] level;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } queue_op_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    queue_op_t pending_ops[$];
    result_t   expected_results[$];

    // Predicted contents of the cell chain, head in entry 0
    logic [KEY_W-1:0]   held_key[CAPACITY];
    logic [PAY_W-1:0]   held_payload[CAPACITY];
    logic [LEVEL_W-1:0] held_level[CAPACITY];
    int                 held_count = 0;

    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    int   mismatches      = 0;
    int   cycle_count     = 0;
    logic in_beat         = 1'b0;

    logic [KEY_W-1:0] key_pool[8] = '{64'd0, KEY_ONES, 64'd5, 64'h8000_0000_0000_0000,
                                      64'h0123_4567_89ab_cdef, 64'd42, 64'hffff_0000_ffff_0000,
                                      64'd7};

    stable_three_level_priority_queue_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic result_t predict_queue_op(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] lvl_in,
                                                 logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        result_t            r;
        logic [LEVEL_W-1:0] lvl;
        int                 pos;
        r        = '0;
        r.status = STAT_OK;
        lvl      = (lvl_in > LEVEL_LOW) ? LEVEL_LOW : lvl_in;
        case (op)
            OP_INSERT:
                if (held_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    // new entry goes behind everything of equal or higher priority
                    pos = 0;
                    while (pos < held_count && held_level[pos] <= lvl)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_key[i]     = held_key[i-1];
                        held_payload[i] = held_payload[i-1];
                        held_level[i]   = held_level[i-1];
                    end
                    held_key[pos]     = key;
                    held_payload[pos] = pay;
                    held_level[pos]   = lvl;
                    held_count++;
                end
            OP_REMOVE:
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.key     = held_key[0];
                    r.payload = held_payload[0];
                    r.level   = held_level[0];
                    for (int i = 0; i + 1 < held_count; i++)
                    begin
                        held_key[i]     = held_key[i+1];
                        held_payload[i] = held_payload[i+1];
                        held_level[i]   = held_level[i+1];
                    end
                    held_count--;
                end
            OP_LOOKUP:
            begin
                r.status = STAT_NOTFOUND;
                for (int i = 0; i < held_count; i++)
                    if (r.status == STAT_NOTFOUND && held_key[i] == key)
                    begin
                        r.status  = STAT_OK;
                        r.key     = held_key[i];
                        r.payload = held_payload[i];
                        r.level   = held_level[i];
                    end
            end
            default: ;
        endcase
        r.count = COUNT_W'(held_count);
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [KEY_W-1:0] want,
                                          logic [KEY_W-1:0] got);
        if (mismatches < 10)
            $display("mismatch in %s at cycle %0d: expected %h, got %h",
                     what, cycle_count, want, got);
        mismatches++;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int bias);
        int roll;
        int ins_th;
        int rem_th;
        roll = $urandom_range(99);
        case (bias)
            0:       begin ins_th = 75; rem_th = 85; end  // filling
            1:       begin ins_th = 25; rem_th = 70; end  // draining
            2:       begin ins_th = 40; rem_th = 70; end
            default: begin ins_th = 35; rem_th = 55; end  // lookups most common
        endcase
        if (roll < 4)
            return OP_UNUSED;
        else if (roll < ins_th)
            return OP_INSERT;
        else if (roll < rem_th)
            return OP_REMOVE;
        else
            return OP_LOOKUP;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(9) < 7)
            return key_pool[$urandom_range(7)];
        else
            return {$urandom, $urandom};
    endfunction

    task automatic push_op(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] lvl,
                           logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        queue_op_t item;
        item.op      = op;
        item.level   = lvl;
        item.key     = key;
        item.payload = pay;
        pending_ops.push_back(item);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: inputs move on the falling edge only
    always @(negedge clk)
    begin
        queue_op_t item;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && (!s_axis_tvalid || in_beat))
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                item = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(S_TDATA_W - LEVEL_W - KEY_W - PAY_W){1'b0}},
                                  item.payload, item.key, item.level};
                s_axis_tuser  <= item.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: predicts on each accepted operation and checks each result beat
    always @(posedge clk)
    begin
        result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            in_beat <= rst_n && s_axis_tvalid && s_axis_tready;
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("unexpected result beat", '0, m_axis_tdata[KEY_W-1:0]);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        note_mismatch("status", KEY_W'(want.status), KEY_W'(m_axis_tuser));
                    if (m_axis_tdata[KEY_W-1:0] !== want.key)
                        note_mismatch("out_key", want.key, m_axis_tdata[KEY_W-1:0]);
                    if (m_axis_tdata[KEY_W +: PAY_W] !== want.payload)
                        note_mismatch("out_payload", want.payload, m_axis_tdata[KEY_W +: PAY_W]);
                    if (m_axis_tdata[KEY_W+PAY_W +: LEVEL_W] !== want.level)
                        note_mismatch("out_level", KEY_W'(want.level),
                                      KEY_W'(m_axis_tdata[KEY_W+PAY_W +: LEVEL_W]));
                    if (m_axis_tdata[KEY_W+PAY_W+LEVEL_W +: COUNT_W] !== want.count)
                        note_mismatch("out_count", KEY_W'(want.count),
                                      KEY_W'(m_axis_tdata[KEY_W+PAY_W+LEVEL_W +: COUNT_W]));
                    if (m_axis_tdata[M_TDATA_W-1:FIELDS_W] !== '0)
                        note_mismatch("zero fill", '0, KEY_W'(m_axis_tdata[M_TDATA_W-1:FIELDS_W]));
                end
            end
            if (rst_n && s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_queue_op(s_axis_tuser,
                                                            s_axis_tdata[LEVEL_W-1:0],
                                                            s_axis_tdata[LEVEL_W +: KEY_W],
                                                            s_axis_tdata[LEVEL_W+KEY_W +: PAY_W]));
        end
    end

    initial
    begin
        int bias;
        bias = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty queue, unused op, level saturation, duplicate keys, full queue
        push_op(OP_REMOVE, LEVEL_HIGH, 64'd0, 64'd0);
        push_op(OP_LOOKUP, LEVEL_HIGH, 64'd0, 64'd0);
        push_op(OP_UNUSED, LEVEL_OVER, KEY_ONES, KEY_ONES);
        push_op(OP_INSERT, LEVEL_LOW, KEY_ONES, 64'd0);
        push_op(OP_INSERT, LEVEL_OVER, 64'd0, KEY_ONES);
        push_op(OP_INSERT, LEVEL_HIGH, 64'd5, 64'h1111);
        push_op(OP_INSERT, LEVEL_MID, 64'd5, 64'h2222);
        push_op(OP_INSERT, LEVEL_HIGH, 64'ha, 64'h3333);
        push_op(OP_LOOKUP, LEVEL_HIGH, 64'd5, 64'd0);
        push_op(OP_LOOKUP, LEVEL_MID, KEY_ONES, 64'd0);
        push_op(OP_LOOKUP, LEVEL_LOW, 64'h1234, 64'd0);
        for (int i = 0; i < CAPACITY - 5; i++)
            push_op(OP_INSERT, LEVEL_W'(i), 64'd100 + i, ~(64'd100 + i));
        push_op(OP_INSERT, LEVEL_HIGH, 64'h5555, 64'h5555);
        push_op(OP_UNUSED, LEVEL_HIGH, 64'd0, 64'd0);
        push_op(OP_LOOKUP, LEVEL_HIGH, 64'd0, 64'd0);
        repeat (3) push_op(OP_REMOVE, LEVEL_HIGH, 64'd0, 64'd0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin sender_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    bias = $urandom_range(3);
                push_op(pick_op(bias), LEVEL_W'($urandom_range(3)), pick_key(),
                        {$urandom, $urandom});
            end
            while (pending_ops.size() != 0 || s_axis_tvalid)
                @(posedge clk);
        end

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
